// ===== sv/mer_pkg.sv =====
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

    // Configuration register map.
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS_X = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS_Y = 2'd3;

    // The fourth mirrored point of a step closes the group.
    localparam logic [1:0] QUAD_LAST = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RX2,
        S_RY2,
        S_SQ,
        S_INIT1,
        S_INIT2,
        S_INIT3,
        S_TEST1,
        S_TEST2,
        S_TEST3,
        S_R1B,
        S_R1C,
        S_R1D,
        S_R1E,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SW4,
        S_SW5,
        S_SW6,
        S_SW7,
        S_R2A,
        S_R2B,
        S_R2C,
        S_R2D,
        S_R2E,
        S_FIN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ACC_PROD,
        ACC_RX2,
        ACC_RY2
    } t_acc_src;

    typedef struct packed {
        logic start;
        logic region;
        logic done;
    } t_emit_ctrl;

endpackage

// ===== sv/mer_mul.sv =====
// Shared unsigned multiplier with a registered product.
module mer_mul #(
    parameter int A_BITS = 31,
    parameter int B_BITS = 11
) (
    input  logic                     i_clk,
    input  logic [A_BITS-1:0]        i_a,
    input  logic [B_BITS-1:0]        i_b,
    output logic [A_BITS+B_BITS-1:0] o_prod
);

    logic [A_BITS+B_BITS-1:0] r_prod;

    // The product always fits the full width, so nothing is lost.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/mer_emit.sv =====
// Output stage that mirrors one point into four quadrants and sends them one at a time.
module mer_emit #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mer_pkg::t_emit_ctrl         i_ctrl,
    input  logic [RADIUS_BITS-1:0]      i_step_x,
    input  logic [RADIUS_BITS-1:0]      i_step_y,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic                        i_out_ready,
    output logic                        o_busy,
    output logic                        o_out_valid,
    output logic signed [COORD_BITS:0]  o_point_x,
    output logic signed [COORD_BITS:0]  o_point_y,
    output logic [1:0]                  o_quadrant,
    output logic                        o_in_region_two,
    output logic                        o_last_of_step,
    output logic                        o_arc_done
);
    import mer_pkg::*;

    localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic [RADIUS_BITS-1:0]      r_x;
    logic [RADIUS_BITS-1:0]      r_y;
    logic                        r_region;
    logic                        r_done;
    logic                        r_active;
    logic [1:0]                  r_cnt;
    logic                        r_out_valid;
    logic signed [COORD_BITS:0]  r_point_x;
    logic signed [COORD_BITS:0]  r_point_y;
    logic [1:0]                  r_quadrant;
    logic                        r_in_region_two;
    logic                        r_last_of_step;
    logic                        r_arc_done;

    logic                        w_load;
    logic signed [SUM_BITS-1:0]  w_cx;
    logic signed [SUM_BITS-1:0]  w_cy;
    logic signed [SUM_BITS-1:0]  w_x;
    logic signed [SUM_BITS-1:0]  w_y;
    logic signed [SUM_BITS-1:0]  w_px;
    logic signed [SUM_BITS-1:0]  w_py;

    // A new result enters the output register when it is empty or being emptied.
    assign w_load = r_active && (!r_out_valid || i_out_ready);

    assign w_cx = SUM_BITS'(i_center_x);
    assign w_cy = SUM_BITS'(i_center_y);
    assign w_x  = signed'(SUM_BITS'(r_x));
    assign w_y  = signed'(SUM_BITS'(r_y));

    // Quadrants 2 and 3 negate x; quadrants 1 and 2 negate y.
    assign w_px = r_cnt[1] ? (w_cx - w_x) : (w_cx + w_x);
    assign w_py = (r_cnt[1] == r_cnt[0]) ? (w_cy + w_y) : (w_cy - w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (w_load) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == QUAD_LAST) begin
                    r_active <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_x      <= i_step_x;
            r_y      <= i_step_y;
            r_region <= i_ctrl.region;
            r_done   <= i_ctrl.done;
        end
        if (w_load) begin
            r_point_x       <= w_px[COORD_BITS:0];
            r_point_y       <= w_py[COORD_BITS:0];
            r_quadrant      <= r_cnt;
            r_in_region_two <= r_region;
            r_last_of_step  <= (r_cnt == QUAD_LAST);
            r_arc_done      <= r_done;
        end
    end

    assign o_busy          = r_active;
    assign o_out_valid     = r_out_valid;
    assign o_point_x       = r_point_x;
    assign o_point_y       = r_point_y;
    assign o_quadrant      = r_quadrant;
    assign o_in_region_two = r_in_region_two;
    assign o_last_of_step  = r_last_of_step;
    assign o_arc_done      = r_arc_done;

endmodule

// ===== sv/midpoint_ellipse_rasterizer.sv =====
// Top level of the midpoint ellipse rasterizer: sequencer, decision adder and configuration.
// The block walks the boundary of an axis-aligned ellipse one point per input transfer:
// i_restart high starts a new arc at (0, radius_y), i_restart low advances the first-quadrant
// point by one midpoint step (region one while radius_y^2*x < radius_x^2*y, then region two
// until y is zero), and every input transfer yields four output transfers, the point mirrored
// into quadrants 0 to 3 in that order with the center added, the fourth one flagged by
// o_last_of_step. Once y reaches zero o_arc_done is set and further steps repeat the final
// point. Center and radii are written through the plain write port and must only change
// while the block is idle. The decision variable is kept as an exact integer four times the
// textbook value, so the quarter and half terms need no rounding. All products go through
// one registered multiplier and all decision updates through one adder, under a small
// sequencer, so o_in_ready is low while an item is at work. The paths of an item, a step
// after the arc has finished, a restart, a region-two step, a region-one step and the step
// that crosses from region one into region two, each make a different number of
// multiplier passes. The final state of an item also waits until the four results of the
// previous item have all entered the output register.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mer_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [COORD_BITS:0]            o_point_x,
    output logic signed [COORD_BITS:0]            o_point_y,
    output logic [1:0]                            o_quadrant,
    output logic                                  o_in_region_two,
    output logic                                  o_last_of_step,
    output logic                                  o_arc_done
);
    import mer_pkg::*;

    // Multiplier operands: a holds up to radius^2 times (2x+1), b up to 2x+1.
    localparam int MUL_A_BITS = 3 * RADIUS_BITS + 1;
    localparam int MUL_B_BITS = RADIUS_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int SQ_BITS    = 2 * RADIUS_BITS;
    localparam int CMP_BITS   = 3 * RADIUS_BITS;
    // Four times radius^4 plus a few bits of headroom for the signed running value.
    localparam int DEC_BITS   = 4 * RADIUS_BITS + 8;

    localparam logic [1:0] SHIFT_X1 = 2'd0;
    localparam logic [1:0] SHIFT_X4 = 2'd2;
    localparam logic [1:0] SHIFT_X8 = 2'd3;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic [RADIUS_BITS-1:0]       r_radius_x;
    logic [RADIUS_BITS-1:0]       r_radius_y;

    // Arc state.
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_restart;
    logic [RADIUS_BITS-1:0] r_x;
    logic [RADIUS_BITS-1:0] r_y;
    logic [DEC_BITS-1:0]    r_dec;
    logic                   r_region;
    logic                   r_finished;

    // Working registers of one item.
    logic [SQ_BITS-1:0]     r_rx2;
    logic [SQ_BITS-1:0]     r_ry2;
    logic [CMP_BITS-1:0]    r_cmp;
    // Set when the current step moves diagonally (both x and y change).
    logic                   r_branch;

    logic [MUL_A_BITS-1:0]  w_mul_a;
    logic [MUL_B_BITS-1:0]  w_mul_b;
    logic [PROD_BITS-1:0]   w_prod;
    logic [MUL_B_BITS-1:0]  w_t;
    logic [RADIUS_BITS-1:0] w_ym;
    logic                   w_less;
    logic                   w_dec_neg;
    logic                   w_dec_zero;

    logic                   w_acc_en;
    logic                   w_acc_clr;
    logic                   w_acc_sub;
    t_acc_src               w_acc_src;
    logic [1:0]             w_acc_sh;
    logic [DEC_BITS-1:0]    w_src;
    logic [DEC_BITS-1:0]    w_term;
    logic [DEC_BITS-1:0]    w_base;
    logic [DEC_BITS-1:0]    w_dec_next;

    t_emit_ctrl             w_emit;
    logic                   w_emit_busy;

    assign w_t        = {r_x, 1'b1};
    assign w_ym       = r_y - 1'b1;
    assign w_less     = r_cmp < w_prod[CMP_BITS-1:0];
    assign w_dec_neg  = r_dec[DEC_BITS-1];
    assign w_dec_zero = (r_dec == '0);

    assign o_in_ready = (r_state == S_IDLE);

    mer_mul #(
        .A_BITS (MUL_A_BITS),
        .B_BITS (MUL_B_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Decision adder: r_dec (or zero) plus or minus a shifted product or squared radius.
    always_comb begin
        unique case (w_acc_src)
            ACC_PROD: w_src = DEC_BITS'(w_prod);
            ACC_RX2:  w_src = DEC_BITS'(r_rx2);
            default:  w_src = DEC_BITS'(r_ry2);
        endcase
        w_term     = w_src << w_acc_sh;
        w_base     = w_acc_clr ? '0 : r_dec;
        w_dec_next = w_base + (w_acc_sub ? ~w_term : w_term) + DEC_BITS'(w_acc_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: each state issues at most one multiplication and one decision update.
    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_acc_en    = 1'b0;
        w_acc_clr   = 1'b0;
        w_acc_sub   = 1'b0;
        w_acc_src   = ACC_PROD;
        w_acc_sh    = SHIFT_X1;
        w_emit      = '0;
        w_emit.region = r_region;
        w_emit.done   = r_finished;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RX2;
                end
            end
            S_RX2: begin
                w_mul_a = MUL_A_BITS'(r_radius_x);
                w_mul_b = MUL_B_BITS'(r_radius_x);
                n_state = S_RY2;
            end
            S_RY2: begin
                w_mul_a = MUL_A_BITS'(r_radius_y);
                w_mul_b = MUL_B_BITS'(r_radius_y);
                n_state = S_SQ;
            end
            S_SQ: begin
                if (r_restart) begin
                    n_state = S_INIT1;
                end else if (r_finished) begin
                    n_state = S_EMIT;
                end else if (!r_region) begin
                    n_state = S_TEST1;
                end else begin
                    n_state = S_R2A;
                end
            end
            // Restart: d = 4*ry2 + rx2 - 4*rx2*ry. The product issued in S_INIT1 is ready in
            // S_INIT2.
            S_INIT1: begin
                w_mul_a   = MUL_A_BITS'(r_rx2);
                w_mul_b   = MUL_B_BITS'(r_radius_y);
                w_acc_en  = 1'b1;
                w_acc_clr = 1'b1;
                w_acc_src = ACC_RY2;
                w_acc_sh  = SHIFT_X4;
                n_state   = S_INIT2;
            end
            S_INIT2: begin
                w_acc_en  = 1'b1;
                w_acc_sub = 1'b1;
                w_acc_sh  = SHIFT_X4;
                n_state   = S_INIT3;
            end
            S_INIT3: begin
                w_acc_en  = 1'b1;
                w_acc_src = ACC_RX2;
                n_state   = S_EMIT;
            end
            // Region-one test: ry2*x against rx2*y.
            S_TEST1: begin
                w_mul_a = MUL_A_BITS'(r_ry2);
                w_mul_b = MUL_B_BITS'(r_x);
                n_state = S_TEST2;
            end
            S_TEST2: begin
                w_mul_a = MUL_A_BITS'(r_rx2);
                w_mul_b = MUL_B_BITS'(r_y);
                n_state = S_TEST3;
            end
            S_TEST3: begin
                n_state = w_less ? S_R1B : S_SW1;
            end
            // Region-one step on the updated x and y.
            S_R1B: begin
                w_mul_a = MUL_A_BITS'(r_ry2);
                w_mul_b = MUL_B_BITS'(r_x);
                n_state = S_R1C;
            end
            S_R1C: begin
                w_mul_a  = MUL_A_BITS'(r_rx2);
                w_mul_b  = MUL_B_BITS'(r_y);
                w_acc_en = 1'b1;
                w_acc_sh = SHIFT_X8;
                n_state  = S_R1D;
            end
            S_R1D: begin
                w_acc_en  = r_branch;
                w_acc_sub = 1'b1;
                w_acc_sh  = SHIFT_X8;
                n_state   = S_R1E;
            end
            S_R1E: begin
                w_acc_en  = 1'b1;
                w_acc_src = ACC_RY2;
                w_acc_sh  = SHIFT_X4;
                n_state   = S_FIN;
            end
            // Region switch: d = ry2*t*t + 4*rx2*ym*ym - 4*rx2*ry*ry, t = 2x+1, ym = y-1.
            S_SW1: begin
                w_mul_a = MUL_A_BITS'(r_ry2);
                w_mul_b = w_t;
                n_state = S_SW2;
            end
            S_SW2: begin
                w_mul_a = w_prod[MUL_A_BITS-1:0];
                w_mul_b = w_t;
                n_state = S_SW3;
            end
            S_SW3: begin
                w_mul_a   = MUL_A_BITS'(r_rx2);
                w_mul_b   = MUL_B_BITS'(w_ym);
                w_acc_en  = 1'b1;
                w_acc_clr = 1'b1;
                n_state   = S_SW4;
            end
            S_SW4: begin
                w_mul_a = w_prod[MUL_A_BITS-1:0];
                w_mul_b = MUL_B_BITS'(w_ym);
                n_state = S_SW5;
            end
            S_SW5: begin
                w_mul_a  = MUL_A_BITS'(r_rx2);
                w_mul_b  = MUL_B_BITS'(r_radius_y);
                w_acc_en = 1'b1;
                w_acc_sh = SHIFT_X4;
                n_state  = S_SW6;
            end
            S_SW6: begin
                w_mul_a = w_prod[MUL_A_BITS-1:0];
                w_mul_b = MUL_B_BITS'(r_radius_y);
                n_state = S_SW7;
            end
            S_SW7: begin
                w_acc_en  = 1'b1;
                w_acc_sub = 1'b1;
                w_acc_sh  = SHIFT_X4;
                n_state   = S_R2A;
            end
            // Region-two step on the updated x and y.
            S_R2A: begin
                n_state = S_R2B;
            end
            S_R2B: begin
                w_mul_a = MUL_A_BITS'(r_rx2);
                w_mul_b = MUL_B_BITS'(r_y);
                n_state = S_R2C;
            end
            S_R2C: begin
                w_mul_a   = MUL_A_BITS'(r_ry2);
                w_mul_b   = MUL_B_BITS'(r_x);
                w_acc_en  = 1'b1;
                w_acc_sub = 1'b1;
                w_acc_sh  = SHIFT_X8;
                n_state   = S_R2D;
            end
            S_R2D: begin
                w_acc_en = r_branch;
                w_acc_sh = SHIFT_X8;
                n_state  = S_R2E;
            end
            S_R2E: begin
                w_acc_en  = 1'b1;
                w_acc_src = ACC_RX2;
                w_acc_sh  = SHIFT_X4;
                n_state   = S_FIN;
            end
            S_FIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!w_emit_busy) begin
                    w_emit.start = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius_x <= RADIUS_BITS'(1);
            r_radius_y <= RADIUS_BITS'(1);
            r_x        <= '0;
            r_y        <= '0;
            r_dec      <= '0;
            r_region   <= 1'b0;
            r_finished <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_CENTER_X: r_center_x <= i_cfg_data[COORD_BITS-1:0];
                    REG_CENTER_Y: r_center_y <= i_cfg_data[COORD_BITS-1:0];
                    REG_RADIUS_X: r_radius_x <= i_cfg_data[RADIUS_BITS-1:0];
                    REG_RADIUS_Y: r_radius_y <= i_cfg_data[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_acc_en) begin
                r_dec <= w_dec_next;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_restart <= i_restart;
                    end
                end
                S_RY2: begin
                    r_rx2 <= w_prod[SQ_BITS-1:0];
                end
                S_SQ: begin
                    r_ry2 <= w_prod[SQ_BITS-1:0];
                end
                S_INIT3: begin
                    r_x        <= '0;
                    r_y        <= r_radius_y;
                    r_region   <= 1'b0;
                    r_finished <= (r_radius_y == '0);
                end
                S_TEST2: begin
                    r_cmp <= w_prod[CMP_BITS-1:0];
                end
                // Region one: x always advances, y drops when the midpoint lies outside.
                S_TEST3: begin
                    if (w_less) begin
                        r_x      <= r_x + 1'b1;
                        r_branch <= !w_dec_neg;
                        if (!w_dec_neg) begin
                            r_y <= r_y - 1'b1;
                        end
                    end
                end
                S_SW7: begin
                    r_region <= 1'b1;
                end
                // Region two: y always drops, x advances when the midpoint lies inside.
                S_R2A: begin
                    r_y      <= r_y - 1'b1;
                    r_branch <= w_dec_neg || w_dec_zero;
                    if (w_dec_neg || w_dec_zero) begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_FIN: begin
                    r_finished <= (r_y == '0);
                end
                default: ;
            endcase
        end
    end

    mer_emit #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_emit),
        .i_step_x        (r_x),
        .i_step_y        (r_y),
        .i_center_x      (r_center_x),
        .i_center_y      (r_center_y),
        .i_out_ready     (i_out_ready),
        .o_busy          (w_emit_busy),
        .o_out_valid     (o_out_valid),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_quadrant      (o_quadrant),
        .o_in_region_two (o_in_region_two),
        .o_last_of_step  (o_last_of_step),
        .o_arc_done      (o_arc_done)
    );

endmodule

// ===== sv/mer_chk.sv =====
// Port-level checker of the midpoint ellipse rasterizer and its bind.
module mer_chk #(
    parameter int COORD_BITS = 12
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [COORD_BITS:0] o_point_x,
    input logic signed [COORD_BITS:0] o_point_y,
    input logic [1:0]                 o_quadrant,
    input logic                       o_last_of_step
);
    import mer_pkg::*;

    // An accepted item keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted in back-to-back cycles");

    // The end-of-group marker sits on the fourth quadrant and nowhere else.
    a_last_on_q3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_of_step == (o_quadrant == QUAD_LAST)))
        else $error("last_of_step does not match quadrant");

    // Within a group the next result follows at once, in quadrant order.
    a_quad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_step
            |=> o_out_valid && (o_quadrant == $past(o_quadrant) + 2'd1))
        else $error("quadrant sequence broken");

    // A stalled result holds its point.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready
            |=> o_out_valid && $stable(o_point_x) && $stable(o_point_y)
                && $stable(o_quadrant))
        else $error("stalled result changed");

endmodule

bind midpoint_ellipse_rasterizer mer_chk #(.COORD_BITS(COORD_BITS)) u_mer_chk (.*);

// ===== verif/midpoint_ellipse_rasterizer_checker.sv =====
// Checker for the midpoint ellipse rasterizer: follows the arc per input transfer and compares points.
`timescale 1ns / 100ps
module midpoint_ellipse_rasterizer_checker #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 12,
    parameter int DATA_BITS   = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mer_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [DATA_BITS-1:0]                  i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_restart,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [COORD_BITS:0]            i_point_x,
    input  logic signed [COORD_BITS:0]            i_point_y,
    input  logic [1:0]                            i_quadrant,
    input  logic                                  i_in_region_two,
    input  logic                                  i_last_of_step,
    input  logic                                  i_arc_done,
    output int                                    o_mismatches,
    output int                                    o_pending
);
    import mer_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic [1:0]                 quadrant;
        logic                       region_two;
        logic                       last;
        logic                       done;
    } t_mirror_point;

    // Copy of the register file as seen on the write port.
    logic [COORD_BITS-1:0]  center_x_reg;
    logic [COORD_BITS-1:0]  center_y_reg;
    logic [RADIUS_BITS-1:0] radius_x_reg;
    logic [RADIUS_BITS-1:0] radius_y_reg;

    // Walk state of the first-quadrant point; the decision is four times the real value.
    logic [RADIUS_BITS-1:0] walk_x;
    logic [RADIUS_BITS-1:0] walk_y;
    logic [63:0]            walk_decision;
    logic                   walk_region_two;
    logic                   walk_done;

    t_mirror_point          awaited_points[$];
    t_mirror_point          oldest_point;
    int                     mismatch_count = 0;
    int                     awaited_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = awaited_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ellipse checker: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Advances the walk for one input transfer and queues the four mirrored points.
    task automatic trace_arc_step(input logic restart);
        logic [63:0]   rx_w;
        logic [63:0]   ry_w;
        logic [63:0]   rx2;
        logic [63:0]   ry2;
        logic [63:0]   x_w;
        logic [63:0]   y_w;
        logic [63:0]   odd;
        logic [63:0]   y_less;
        int            cx;
        int            cy;
        int            xv;
        int            yv;
        t_mirror_point pt;
        rx_w = 64'(radius_x_reg);
        ry_w = 64'(radius_y_reg);
        rx2  = rx_w * rx_w;
        ry2  = ry_w * ry_w;
        x_w  = 64'(walk_x);
        y_w  = 64'(walk_y);
        if (restart) begin
            walk_x          = '0;
            walk_y          = radius_y_reg;
            walk_decision   = 64'd4 * ry2 - 64'd4 * rx2 * ry_w + rx2;
            walk_region_two = 1'b0;
            walk_done       = (walk_y == '0);
        end else if (!walk_done) begin
            if (!walk_region_two && (ry2 * x_w < rx2 * y_w)) begin
                walk_x = walk_x + 1'b1;
                x_w    = 64'(walk_x);
                if ($signed(walk_decision) < 0) begin
                    walk_decision = walk_decision + 64'd8 * ry2 * x_w + 64'd4 * ry2;
                end else begin
                    walk_y        = walk_y - 1'b1;
                    y_w           = 64'(walk_y);
                    walk_decision = walk_decision + 64'd8 * ry2 * x_w
                                    - 64'd8 * rx2 * y_w + 64'd4 * ry2;
                end
            end else begin
                // Crossing into region two reloads the decision from the current point.
                if (!walk_region_two) begin
                    odd             = 64'd2 * x_w + 64'd1;
                    y_less          = y_w - 64'd1;
                    walk_region_two = 1'b1;
                    walk_decision   = ry2 * odd * odd + 64'd4 * rx2 * y_less * y_less
                                      - 64'd4 * rx2 * ry2;
                end
                walk_y = walk_y - 1'b1;
                y_w    = 64'(walk_y);
                if ($signed(walk_decision) > 0) begin
                    walk_decision = walk_decision + 64'd4 * rx2 - 64'd8 * rx2 * y_w;
                end else begin
                    walk_x        = walk_x + 1'b1;
                    x_w           = 64'(walk_x);
                    walk_decision = walk_decision + 64'd8 * ry2 * x_w
                                    - 64'd8 * rx2 * y_w + 64'd4 * rx2;
                end
            end
            walk_done = (walk_y == '0);
        end
        cx = int'($signed(center_x_reg));
        cy = int'($signed(center_y_reg));
        xv = int'(walk_x);
        yv = int'(walk_y);
        for (int k = 0; k < 4; k++) begin
            pt.quadrant   = 2'(k);
            pt.x          = (COORD_BITS+1)'((k < 2) ? cx + xv : cx - xv);
            pt.y          = (COORD_BITS+1)'((k == 0 || k == 3) ? cy + yv : cy - yv);
            pt.region_two = walk_region_two;
            pt.last       = (pt.quadrant == QUAD_LAST);
            pt.done       = walk_done;
            awaited_points.push_back(pt);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            center_x_reg    = '0;
            center_y_reg    = '0;
            radius_x_reg    = RADIUS_BITS'(1);
            radius_y_reg    = RADIUS_BITS'(1);
            walk_x          = '0;
            walk_y          = '0;
            walk_decision   = '0;
            walk_region_two = 1'b0;
            walk_done       = 1'b1;
            awaited_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_points.size() == 0) begin
                    report_mismatch("point with nothing awaited, x", i_point_x, 0);
                end else begin
                    oldest_point = awaited_points.pop_front();
                    if (i_point_x !== oldest_point.x)
                        report_mismatch("point_x", i_point_x, $signed(oldest_point.x));
                    if (i_point_y !== oldest_point.y)
                        report_mismatch("point_y", i_point_y, $signed(oldest_point.y));
                    if (i_quadrant !== oldest_point.quadrant)
                        report_mismatch("quadrant", i_quadrant, oldest_point.quadrant);
                    if (i_in_region_two !== oldest_point.region_two)
                        report_mismatch("in_region_two", i_in_region_two,
                                        oldest_point.region_two);
                    if (i_last_of_step !== oldest_point.last)
                        report_mismatch("last_of_step", i_last_of_step, oldest_point.last);
                    if (i_arc_done !== oldest_point.done)
                        report_mismatch("arc_done", i_arc_done, oldest_point.done);
                end
            end
            if (i_in_valid && i_in_ready) begin
                trace_arc_step(i_restart);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_CENTER_X: begin
                        center_x_reg = i_cfg_data[COORD_BITS-1:0];
                    end
                    REG_CENTER_Y: begin
                        center_y_reg = i_cfg_data[COORD_BITS-1:0];
                    end
                    REG_RADIUS_X: begin
                        radius_x_reg = i_cfg_data[RADIUS_BITS-1:0];
                    end
                    REG_RADIUS_Y: begin
                        radius_y_reg = i_cfg_data[RADIUS_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        awaited_count = awaited_points.size();
    end

endmodule

// ===== verif/midpoint_ellipse_rasterizer_tb.sv =====
// Testbench top for the midpoint ellipse rasterizer: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module midpoint_ellipse_rasterizer_tb;
    import mer_pkg::*;

    localparam int RADIUS_BITS  = 10;
    localparam int COORD_BITS   = 12;
    localparam int DATA_BITS    = 12;
    localparam int RANDOM_ITEMS = 180;
    // The slowest item (the crossing into region two) must fit in the drain; leave margin.
    localparam int DRAIN_CYCLES = 30;
    // Longest quiet stretch in a correct run is a sender gap, the slowest item and a
    // receiver stall, or a drain plus register writes; this is many times that.
    localparam int STALL_LIMIT  = 4000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_ADDR_BITS-1:0]    i_cfg_addr;
    logic [DATA_BITS-1:0]        i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_restart;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [COORD_BITS:0]  o_point_x;
    logic signed [COORD_BITS:0]  o_point_y;
    logic [1:0]                  o_quadrant;
    logic                        o_in_region_two;
    logic                        o_last_of_step;
    logic                        o_arc_done;

    int                          mismatches;
    int                          points_awaited;
    int                          items_sent = 0;
    // When set, the matching side runs without any idle cycles for a whole phase.
    bit                          sender_calm   = 1'b0;
    bit                          receiver_calm = 1'b0;
    // Radii currently programmed, used to size the step runs.
    int                          shape_rx = 1;
    int                          shape_ry = 1;

    midpoint_ellipse_rasterizer #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_quadrant      (o_quadrant),
        .o_in_region_two (o_in_region_two),
        .o_last_of_step  (o_last_of_step),
        .o_arc_done      (o_arc_done)
    );

    midpoint_ellipse_rasterizer_checker #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS),
        .DATA_BITS   (DATA_BITS)
    ) point_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_restart       (i_restart),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_point_x       (o_point_x),
        .i_point_y       (o_point_y),
        .i_quadrant      (o_quadrant),
        .i_in_region_two (o_in_region_two),
        .i_last_of_step  (o_last_of_step),
        .i_arc_done      (o_arc_done),
        .o_mismatches    (mismatches),
        .o_pending       (points_awaited)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    // Offers one item on the input channel and returns at the falling edge after its
    // transfer. Valid is only lowered when a gap follows, so back-to-back items keep it
    // high without a low/high pair in the same time step.
    task automatic push_item(input logic restart);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every point of the items sent so far has been taken,
    // then lets the sequencer run out before anything else changes.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (points_awaited != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Programs the whole ellipse; the caller has already let the block go idle.
    task automatic set_shape(input logic [DATA_BITS-1:0] cx, input logic [DATA_BITS-1:0] cy,
                             input int rx, input int ry);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS_X, DATA_BITS'(rx));
        write_reg(REG_RADIUS_Y, DATA_BITS'(ry));
        shape_rx = rx;
        shape_ry = ry;
    endtask

    task automatic walk_steps(input int count);
        for (int n = 0; n < count; n++) begin
            push_item(1'b0);
        end
    endtask

    // One random phase. Most phases are a restart followed by a well-formed run of steps
    // that usually walks the arc past its end; a few keep the current arc going after a
    // register change, and a stray restart now and then breaks a run.
    task automatic random_phase();
        int kind;
        int count;
        settle();
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_CENTER_X, DATA_BITS'($urandom_range(0, 4095)));
            write_reg(REG_CENTER_Y, DATA_BITS'($urandom_range(0, 4095)));
        end
        kind = int'($urandom_range(0, 9));
        if (kind == 0) begin
            // Extreme radii, 1 or 1023, can make long arcs, so only the first few points are walked.
            shape_rx = $urandom_range(0, 1) ? 1023 : 1;
            shape_ry = $urandom_range(0, 1) ? 1023 : 1;
            write_reg(REG_RADIUS_X, DATA_BITS'(shape_rx));
            write_reg(REG_RADIUS_Y, DATA_BITS'(shape_ry));
            count = int'($urandom_range(1, 6));
        end else if (kind < 9) begin
            shape_rx = int'($urandom_range(1, 20));
            shape_ry = int'($urandom_range(1, 20));
            write_reg(REG_RADIUS_X, DATA_BITS'(shape_rx));
            write_reg(REG_RADIUS_Y, DATA_BITS'(shape_ry));
            count = int'($urandom_range((shape_rx + shape_ry) / 2, shape_rx + shape_ry + 3));
        end else begin
            count = int'($urandom_range(1, 10));
        end
        if (kind < 9) begin
            push_item(1'b1);
        end
        for (int n = 0; n < count; n++) begin
            push_item($urandom_range(0, 19) == 0);
        end
    endtask

    // Receiver: draws a stall before every point and then waits for the transfer.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(receiver_calm);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Watchdog: ends the run when no transfer happens on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int directed_items;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = REG_CENTER_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_restart  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A step straight out of reset finds no active arc and repeats (0,0) as done.
        push_item(1'b0);

        // Smallest radii around the most negative x and most positive y center: the arc
        // ends on the first step and the next one repeats the final point.
        settle();
        set_shape(12'h800, 12'h7FF, 1, 1);
        push_item(1'b1);
        walk_steps(2);

        // A zero vertical radius finishes the arc on the restart itself.
        settle();
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        set_shape(12'h005, 12'hFFB, 5, 0);
        push_item(1'b1);
        walk_steps(1);

        // A zero horizontal radius goes straight to region two and walks y down.
        settle();
        sender_calm   = 1'b0;
        set_shape(12'h000, 12'h000, 0, 3);
        push_item(1'b1);
        walk_steps(4);

        // A small ellipse crosses from region one to region two; the center is moved
        // halfway along, and the remaining steps must use the new value.
        settle();
        receiver_calm = 1'b0;
        set_shape(12'd100, 12'hFCE, 4, 3);
        push_item(1'b1);
        walk_steps(3);
        settle();
        write_reg(REG_CENTER_X, 12'hFF9);
        walk_steps(6);

        // Largest radii about the most positive x and most negative y center reach the
        // vertical output extremes on the restart.
        settle();
        set_shape(12'h7FF, 12'h800, 1023, 1023);
        push_item(1'b1);
        walk_steps(2);

        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            random_phase();
        end

        i_in_valid <= 1'b0;
        while (points_awaited != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
